// File: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, inactive during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Types and fixed constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfba_pkg;

    localparam int GRANULE_BYTES = 16;
    localparam int GRAN_LOG      = $clog2(GRANULE_BYTES);
    localparam int HEADER_BYTES  = 8;

    localparam int WORD_W = 32;
    localparam int SIZE_W = WORD_W - GRAN_LOG;      // granule count held in a header
    localparam int REQ_W  = 16;
    localparam int TOT_W  = REQ_W + 1 - GRAN_LOG;   // rounded request in granules

    localparam int BUSY_POS = 0;
    localparam int PREV_POS = 1;
    localparam logic [WORD_W-1:0] BUSY_MASK = WORD_W'(1) << BUSY_POS;
    localparam logic [WORD_W-1:0] PREV_MASK = WORD_W'(1) << PREV_POS;
    localparam logic [WORD_W-1:0] END_MARK  = BUSY_MASK;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_WRITE = 2'd0;
    localparam t_kind KIND_READ  = 2'd1;
    localparam t_kind KIND_ALLOC = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_ZERO  = 2'd1;
    localparam t_status ST_NOFIT = 2'd2;

    typedef struct packed {
        t_kind             kind;
        logic [11:0]       granule_index;
        logic [WORD_W-1:0] header_value;
        logic [REQ_W-1:0]  request_bytes;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [15:0]       payload_offset;
        logic [WORD_W-1:0] read_value;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/bfba_hdr_mem.sv
// ----------------------------------------------------------------------------
// bfba_hdr_mem
// Header word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_hdr_mem
    import bfba_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [WORD_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/bfba_out_stage.sv
// ----------------------------------------------------------------------------
// bfba_out_stage
// Result register between the engine and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_out_stage
    import bfba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_room,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    logic      r_valid;
    t_out_item r_item;

    // free, or the held word leaves this cycle
    assign o_room = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_room) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_item;

endmodule

`default_nettype wire

// File: src/bfba_engine.sv
// ----------------------------------------------------------------------------
// bfba_engine
// Sequencer: header writes and reads, best-fit walk, split and mark.
// ----------------------------------------------------------------------------
`default_nettype none

module bfba_engine
    import bfba_pkg::*;
#(
    parameter int HEAP_GRANULES = 4096,
    parameter int AW            = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in,
    output logic                   o_mem_we,
    output logic      [AW-1:0]     o_mem_waddr,
    output logic      [WORD_W-1:0] o_mem_wdata,
    output logic      [AW-1:0]     o_mem_raddr,
    input  wire logic [WORD_W-1:0] i_mem_rdata,
    output logic                   o_push,
    output t_out_item              o_res,
    input  wire logic              i_room
);

    localparam int IW = AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_CARVE,
        S_MARK,
        S_FOLLOW,
        S_PUSH
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_idx;
    logic [TOT_W-1:0] r_total;
    logic             r_found;
    logic [AW-1:0]    r_best;
    logic [IW-1:0]    r_best_g;
    logic             r_best_prev;
    logic [AW-1:0]    r_nxt;
    t_out_item        r_res;

    logic              gi_ok;
    logic [AW-1:0]     gi_addr;
    logic [REQ_W:0]    req_sum;
    logic [TOT_W-1:0]  total_g;
    logic [SIZE_W-1:0] blk_g;
    logic [SIZE_W:0]   blk_end;
    logic              blk_fits;
    logic              take;
    logic              walk_done;
    logic              split;
    logic [SIZE_W-1:0] used_g;
    logic [SIZE_W-1:0] nxt_wide;
    logic              nxt_in;
    logic [AW-1:0]     rem_addr;
    logic [WORD_W-1:0] rem_word;
    logic [WORD_W-1:0] head_word;
    logic [15:0]       offset;

    assign o_in_stall = (r_state != S_IDLE);

    assign gi_ok   = WORD_W'(i_in.granule_index) < WORD_W'(HEAP_GRANULES);
    assign gi_addr = AW'(i_in.granule_index);

    // request plus header, rounded up to whole granules
    assign req_sum = (REQ_W+1)'(i_in.request_bytes)
                   + (REQ_W+1)'(HEADER_BYTES + GRANULE_BYTES - 1);
    assign total_g = req_sum[REQ_W:GRAN_LOG];

    // walk step on the header just read
    assign blk_g     = i_mem_rdata[WORD_W-1:GRAN_LOG];
    assign blk_end   = (SIZE_W+1)'(r_idx) + (SIZE_W+1)'(blk_g);
    assign blk_fits  = !i_mem_rdata[BUSY_POS] && (blk_g >= SIZE_W'(r_total))
                    && (blk_end <= (SIZE_W+1)'(HEAP_GRANULES));
    assign take      = blk_fits && (!r_found || (blk_g < SIZE_W'(r_best_g)));
    assign walk_done = (blk_g == '0) || (blk_end >= (SIZE_W+1)'(HEAP_GRANULES));

    // commit of the chosen block
    assign split     = SIZE_W'(r_best_g) > SIZE_W'(r_total);
    assign used_g    = split ? SIZE_W'(r_total) : SIZE_W'(r_best_g);
    assign nxt_wide  = SIZE_W'(r_best) + used_g;
    assign nxt_in    = nxt_wide < SIZE_W'(HEAP_GRANULES);
    assign rem_addr  = AW'(SIZE_W'(r_best) + SIZE_W'(r_total));
    assign rem_word  = {SIZE_W'(r_best_g) - SIZE_W'(r_total), {GRAN_LOG{1'b0}}} | PREV_MASK;
    assign head_word = {used_g, {GRAN_LOG{1'b0}}} | BUSY_MASK
                     | (r_best_prev ? PREV_MASK : '0);
    assign offset    = 16'((WORD_W'(r_best) << GRAN_LOG) + WORD_W'(HEADER_BYTES));

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = gi_addr;
        o_mem_wdata = i_in.header_value;
        o_mem_raddr = gi_addr;
        case (r_state)
            S_IDLE: begin
                o_mem_we = i_in_valid && (i_in.kind == KIND_WRITE) && gi_ok;
                if (i_in.kind == KIND_ALLOC) begin
                    o_mem_raddr = '0;
                end
            end
            S_WALK: begin
                o_mem_raddr = AW'(blk_end);
            end
            S_CARVE: begin
                o_mem_we    = r_found && split;
                o_mem_waddr = rem_addr;
                o_mem_wdata = rem_word;
            end
            S_MARK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_best;
                o_mem_wdata = head_word;
                o_mem_raddr = AW'(nxt_wide);
            end
            S_FOLLOW: begin
                o_mem_we    = (i_mem_rdata != END_MARK);
                o_mem_waddr = r_nxt;
                o_mem_wdata = i_mem_rdata | PREV_MASK;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in.kind)
                            KIND_READ: begin
                                r_res   <= '0;
                                r_state <= gi_ok ? S_READ : S_PUSH;
                            end
                            KIND_ALLOC: begin
                                r_idx   <= '0;
                                r_found <= 1'b0;
                                r_total <= total_g;
                                if (i_in.request_bytes == '0) begin
                                    r_res   <= {ST_ZERO, 16'd0, {WORD_W{1'b0}}};
                                    r_state <= S_PUSH;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_PUSH;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res.read_value <= i_mem_rdata;
                    r_state          <= S_PUSH;
                end
                S_WALK: begin
                    if (take) begin
                        r_found     <= 1'b1;
                        r_best      <= r_idx;
                        r_best_g    <= IW'(blk_g);
                        r_best_prev <= i_mem_rdata[PREV_POS];
                    end
                    if (walk_done) begin
                        r_state <= S_CARVE;
                    end else begin
                        r_idx <= AW'(blk_end);
                    end
                end
                S_CARVE: begin
                    if (!r_found) begin
                        r_res.status <= ST_NOFIT;
                        r_state      <= S_PUSH;
                    end else begin
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_res.payload_offset <= offset;
                    r_nxt                <= AW'(nxt_wide);
                    // after a split the follower is the new free block, already marked
                    r_state <= (!split && nxt_in) ? S_FOLLOW : S_PUSH;
                end
                S_FOLLOW: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_push = (r_state == S_PUSH);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: src/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over an implicit list of block header words.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_stall   t_in_item
//   out      output     o_out_valid / i_out_stall t_out_item
//
// Allocate walks the block headers one header a cycle from the single read
// port, then commits the best fit and pushes the result.
// Reset clears control only; the header memory holds nothing until written.
// A result waits in the output register while a new word is taken in;
// the next result waits in the engine until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_allocator
    import bfba_pkg::*;
#(
    parameter int HEAP_GRANULES = 4096
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out
);

    localparam int AW = $clog2(HEAP_GRANULES);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    logic              push;
    t_out_item         res;
    logic              room;

    bfba_hdr_mem #(
        .DEPTH (HEAP_GRANULES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bfba_engine #(
        .HEAP_GRANULES (HEAP_GRANULES),
        .AW            (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_push      (push),
        .o_res       (res),
        .i_room      (room)
    );

    bfba_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: src/bfba_checker.sv
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks on the result channel of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bfba_checker
    import bfba_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out), "stalled result changed")
    `ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_out_valid, (o_out.status == ST_OK) || (o_out.status == ST_ZERO) || (o_out.status == ST_NOFIT), "unknown status")
    `ASSERT_IMPL(a_err_clean, i_clk, i_rst_n, o_out_valid && (o_out.status != ST_OK), (o_out.payload_offset == '0) && (o_out.read_value == '0), "error result carries data")
    `ASSERT_IMPL(a_offset_align, i_clk, i_rst_n, o_out_valid && (o_out.payload_offset != '0), o_out.payload_offset[GRAN_LOG-1:0] == GRAN_LOG'(HEADER_BYTES), "payload offset off granule grid")

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (.*);

`default_nettype wire

// File: tb/best_fit_block_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_test
// Self-checking bench for the best-fit allocator. A shadow heap of header
// words predicts every reply: writes, reads, and allocate walks with split
// and follower update. Heap images are laid down, then mixed with allocs,
// frees, reads and stray writes under random idling on both channels.
// ----------------------------------------------------------------------------

module best_fit_block_allocator_test;
    import bfba_pkg::*;

    localparam int HEAP_GRANULES = 4096;
    localparam int ITEM_TARGET   = 1800;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 200;
    localparam t_kind KIND_UNUSED = 2'd3;

    class heap_scoreboard;
        bit [WORD_W-1:0] headers [HEAP_GRANULES];
        bit              written [HEAP_GRANULES];
        t_out_item       replies_due [$];
        int              errors = 0;

        function bit [WORD_W-1:0] header_bytes(bit [WORD_W-1:0] hdr);
            return hdr & ~WORD_W'(GRANULE_BYTES - 1);
        endfunction

        function longint rounded_total(logic [REQ_W-1:0] req);
            return ((longint'(req) + HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES)
                   * GRANULE_BYTES;
        endfunction

        // clean drops when the walk touches a header that was never stored
        function void walk_for_fit(input longint total, output bit found, output longint best,
                                   output longint best_size, output bit clean);
            longint idx, sz, span;
            bit [WORD_W-1:0] hdr;
            found = 1'b0;
            best = 0;
            best_size = 0;
            clean = 1'b1;
            idx = 0;
            while (idx < HEAP_GRANULES) begin
                clean &= written[idx];
                hdr = headers[idx];
                if (hdr == END_MARK) break;
                sz = header_bytes(hdr);
                if (sz == 0) break;
                span = sz / GRANULE_BYTES;
                if (!hdr[BUSY_POS] && sz >= total && idx + span <= HEAP_GRANULES
                        && (!found || sz < best_size)) begin
                    found = 1'b1;
                    best = idx;
                    best_size = sz;
                end
                idx += span;
            end
        endfunction

        // an allocate may only touch stored headers, the follower included;
        // after a split the follower is the freshly stored remainder
        function bit alloc_is_safe(logic [REQ_W-1:0] req);
            bit found, clean;
            longint best, best_size, total, follow;
            if (req == 0) return 1'b1;
            total = rounded_total(req);
            walk_for_fit(total, found, best, best_size, clean);
            if (!clean) return 1'b0;
            if (!found || best_size > total) return 1'b1;
            follow = best + best_size / GRANULE_BYTES;
            return follow >= HEAP_GRANULES || written[follow];
        endfunction

        function int pick_block_start();
            int starts [$];
            longint idx, sz;
            idx = 0;
            while (idx < HEAP_GRANULES && written[idx] && starts.size() < 256) begin
                if (headers[idx] == END_MARK) break;
                starts.push_back(int'(idx));
                sz = header_bytes(headers[idx]);
                if (sz == 0) break;
                idx += sz / GRANULE_BYTES;
            end
            if (starts.size() == 0) return 0;
            return starts[$urandom_range(0, starts.size() - 1)];
        endfunction

        function void take_command(t_in_item w);
            t_out_item reply;
            bit found, clean;
            longint total, best, best_size, used, follow;
            bit [WORD_W-1:0] keep_prev;
            reply = '0;
            case (w.kind)
                KIND_WRITE: begin
                    headers[w.granule_index] = w.header_value;
                    written[w.granule_index] = 1'b1;
                end
                KIND_READ: begin
                    reply.read_value = headers[w.granule_index];
                end
                KIND_ALLOC: begin
                    if (w.request_bytes == 0) begin
                        reply.status = ST_ZERO;
                    end else begin
                        total = rounded_total(w.request_bytes);
                        walk_for_fit(total, found, best, best_size, clean);
                        if (!found) begin
                            reply.status = ST_NOFIT;
                        end else begin
                            keep_prev = headers[best] & PREV_MASK;
                            used = best_size;
                            if (best_size > total) begin
                                // tail of the block stays free, behind a busy one
                                headers[best + total / GRANULE_BYTES] =
                                    WORD_W'(best_size - total) | PREV_MASK;
                                written[best + total / GRANULE_BYTES] = 1'b1;
                                used = total;
                            end
                            headers[best] = WORD_W'(used) | BUSY_MASK | keep_prev;
                            follow = best + used / GRANULE_BYTES;
                            if (follow < HEAP_GRANULES && headers[follow] != END_MARK)
                                headers[follow] |= PREV_MASK;
                            reply.payload_offset = 16'(best * GRANULE_BYTES + HEADER_BYTES);
                        end
                    end
                end
                default: ;
            endcase
            replies_due.push_back(reply);
        endfunction

        function void field_check(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want) begin
                if (errors < 100)
                    $display("%0t: %s expected %h got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none pending, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            field_check("status", WORD_W'(want.status), WORD_W'(got.status));
            field_check("payload_offset", WORD_W'(want.payload_offset),
                        WORD_W'(got.payload_offset));
            field_check("read_value", want.read_value, got.read_value);
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    heap_scoreboard sb = new;
    int sent = 0;
    bit calm_tail = 1'b0;
    bit hold_out = 1'b0;
    bit tx_noisy = 1'b1;
    int tx_phase_left = 0;

    best_fit_block_allocator #(
        .HEAP_GRANULES(HEAP_GRANULES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_reply(o_out);
    end

    // receiver: short stall bursts in noisy stretches, one long hold on request
    initial begin : out_stall_gen
        int phase_left;
        bit noisy;
        phase_left = 0;
        noisy = 1'b1;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_out = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!calm_tail && noisy && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            if (phase_left == 0) begin
                noisy = $urandom_range(0, 2) != 0;
                phase_left = $urandom_range(50, 400);
            end else begin
                phase_left--;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("best_fit_block_allocator verification failed");
        $finish;
    end

    function automatic t_in_item filler_word();
        t_in_item w;
        w.kind = KIND_UNUSED;
        w.granule_index = 12'($urandom);
        w.header_value = $urandom;
        w.request_bytes = 16'($urandom);
        return w;
    endfunction

    function automatic t_in_item write_word(int idx, logic [WORD_W-1:0] value);
        t_in_item w;
        w = filler_word();
        w.kind = KIND_WRITE;
        w.granule_index = 12'(idx);
        w.header_value = value;
        return w;
    endfunction

    function automatic t_in_item read_word(int idx);
        t_in_item w;
        w = filler_word();
        w.kind = KIND_READ;
        w.granule_index = 12'(idx);
        return w;
    endfunction

    function automatic t_in_item alloc_word(int req);
        t_in_item w;
        w = filler_word();
        w.kind = KIND_ALLOC;
        w.request_bytes = 16'(req);
        return w;
    endfunction

    task automatic send_word(input t_in_item w);
        if (tx_phase_left == 0) begin
            tx_noisy = $urandom_range(0, 2) != 0;
            tx_phase_left = $urandom_range(10, 80);
        end else begin
            tx_phase_left--;
        end
        if (!calm_tail && tx_noisy && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_command(w);
        sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.replies_due.size() != 0);
    endtask

    // a walk into never-stored headers is not allowed, so read instead
    task automatic send_alloc(int req);
        if (sb.alloc_is_safe(16'(req)))
            send_word(alloc_word(req));
        else
            send_word(read_word(sb.pick_block_start()));
    endtask

    task automatic send_read();
        int idx;
        idx = $urandom_range(0, HEAP_GRANULES - 1);
        if (!sb.written[idx]) idx = sb.pick_block_start();
        send_word(read_word(idx));
    endtask

    task automatic run_episode();
        int nblk, gran, g, pick, req, idx;
        bit busy, prev;
        logic [WORD_W-1:0] hdr;
        // lay down a fresh block list from granule 0
        nblk = $urandom_range(3, 40);
        gran = 0;
        prev = $urandom_range(0, 1);
        for (int b = 0; b < nblk && gran < HEAP_GRANULES; b++) begin
            g = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
            if (gran + g > HEAP_GRANULES) g = HEAP_GRANULES - gran;
            busy = $urandom_range(0, 1);
            hdr = WORD_W'(g * GRANULE_BYTES) | (busy ? BUSY_MASK : '0) | (prev ? PREV_MASK : '0);
            if ($urandom_range(0, 5) == 0) hdr[3:2] = 2'($urandom);
            send_word(write_word(gran, hdr));
            prev = busy;
            gran += g;
        end
        if (gran < HEAP_GRANULES) send_word(write_word(gran, END_MARK));
        repeat ($urandom_range(15, 60)) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) req = 0;
                else if (pick < 80) req = $urandom_range(1, 256);
                else if (pick < 95) req = $urandom_range(257, 4096);
                else req = $urandom_range(0, 65535);
                send_alloc(req);
            end else if (pick < 68) begin
                send_read();
            end else if (pick < 86) begin
                // free a block in place, no coalescing
                idx = sb.pick_block_start();
                send_word(write_word(idx, sb.headers[idx] & ~BUSY_MASK));
            end else if (pick < 93) begin
                idx = $urandom_range(0, HEAP_GRANULES - 1);
                if ($urandom_range(0, 1))
                    hdr = $urandom;
                else
                    hdr = WORD_W'($urandom_range(0, 16) * GRANULE_BYTES) | WORD_W'($urandom_range(0, 3));
                send_word(write_word(idx, hdr));
            end else begin
                send_word(filler_word());
            end
        end
    endtask

    initial begin : stimulus
        bit held_once, paused_once;
        held_once = 1'b0;
        paused_once = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small hand-built heap: 64 free, 32 busy, 32 free with stray size bits
        send_word(write_word(0, 32'h0000_0040));
        send_word(write_word(4, 32'h0000_0023));
        send_word(write_word(6, 32'h0000_002E));
        send_word(write_word(8, END_MARK));
        send_word(read_word(6));
        send_alloc(0);
        send_alloc(24);                 // exact fit at 6, follower is the end mark
        send_alloc(1);                  // splits the 64 byte block
        send_alloc(65535);
        send_word(read_word(1));
        send_alloc(40);
        send_alloc(1);                  // everything busy
        send_word({KIND_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF});
        send_word(write_word(4, 32'h0000_0022));
        send_alloc(16);
        send_word(write_word(8, 32'h0000_FF80));    // last block ends at the heap end
        send_alloc(100);
        send_alloc(65288);              // takes the tail, follower past the heap
        send_word(write_word(0, 32'h0010_0000));    // block runs past the heap
        send_alloc(8);
        send_word(write_word(0, 32'h0000_0008));    // zero size but not the end mark
        send_alloc(1);
        send_word(write_word(0, 32'hFFFF_FFFF));
        send_word(read_word(0));
        send_word(write_word(HEAP_GRANULES - 1, 32'h0000_0000));
        send_word(read_word(HEAP_GRANULES - 1));

        while (sent < ITEM_TARGET) begin
            if (!held_once && sent >= 600) begin
                // output held off while words keep coming, so the input backs up
                hold_out = 1'b1;
                repeat (24) send_read();
                held_once = 1'b1;
            end
            if (!paused_once && sent >= 1200) begin
                wait_drained();
                paused_once = 1'b1;
            end
            if (sent >= ITEM_TARGET - 150) calm_tail = 1'b1;
            run_episode();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.replies_due.size() == 0)
            $display("best_fit_block_allocator verification clean");
        else
            $display("best_fit_block_allocator verification failed");
        $finish;
    end

endmodule
